// ----- rtl/core/ttef_pkg.sv -----
// Shared types and constants for the timeout table with event FIFO.
package ttef_pkg;

    localparam int MODE_W = 2;
    localparam int ID_W   = 8;
    localparam int DUR_W  = 32;
    localparam int STEP_W = 10;
    localparam int REM_W  = 33;
    localparam int OCC_W  = 5;
    localparam int CNT_W  = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_POST = 2'd0,
        MODE_POP  = 2'd1,
        MODE_ADD  = 2'd2,
        MODE_TICK = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        B_IDLE,
        B_POP_RD,
        B_ADD_SCAN,
        B_TICK_RD,
        B_TICK_EX,
        B_DONE
    } t_bstate;

    typedef struct packed {
        t_mode             mode;
        logic [ID_W-1:0]   id;
        logic [DUR_W-1:0]  duration;
    } t_cmd;

endpackage

// ----- rtl/core/ttef_in_if.sv -----
// Input channel: command items with valid/ready handshake.
interface ttef_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  event_id;
    logic [31:0] duration_ms;

    modport source(output valid, mode, event_id, duration_ms, input ready);
    modport sink(input valid, mode, event_id, duration_ms, output ready);
endinterface

// ----- rtl/core/ttef_out_if.sv -----
// Output channel: result items with valid/ready handshake.
interface ttef_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] popped_id;
    logic       popped_valid;
    logic [4:0] occupancy;
    logic [3:0] expired_count;
    logic [3:0] dropped_count;

    modport source(output valid, status, popped_id, popped_valid, occupancy,
                   expired_count, dropped_count, input ready);
    modport sink(input valid, status, popped_id, popped_valid, occupancy,
                 expired_count, dropped_count, output ready);
endinterface

// ----- rtl/core/ttef_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module ttef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/ttef_front.sv -----
// Front end: accepts command items, decodes them and queues them for the back end.
module ttef_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ttef_in_if.sink        i_item,
    output logic           o_cmd_valid,
    output ttef_pkg::t_cmd o_cmd,
    input  logic           i_cmd_ready
);
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    ttef_pkg::t_cmd r_q [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_cnt;
    logic           w_push, w_pop;
    ttef_pkg::t_cmd w_dec;

    assign i_item.ready = (r_cnt != QCW'(QDEPTH));
    assign w_push       = i_item.valid && i_item.ready;
    assign o_cmd_valid  = (r_cnt != '0);
    assign w_pop        = o_cmd_valid && i_cmd_ready;
    assign o_cmd        = r_q[r_rp];

    always_comb begin
        w_dec.mode     = ttef_pkg::t_mode'(i_item.mode);
        w_dec.id       = i_item.event_id;
        w_dec.duration = i_item.duration_ms;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == QAW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == QAW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_dec;
        end
    end
endmodule

// ----- rtl/core/ttef_back.sv -----
// Back end: runs queued commands against the event FIFO and the timeout table.
module ttef_back #(
    parameter int FIFO_DEPTH    = 16,
    parameter int TIMEOUT_SLOTS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  ttef_pkg::t_cmd              i_cmd,
    output logic                        o_cmd_ready,
    input  logic [ttef_pkg::STEP_W-1:0] i_tick_step,
    ttef_out_if.source                  o_result
);
    localparam int FAW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FCW = $clog2(FIFO_DEPTH + 1);
    localparam int TAW = (TIMEOUT_SLOTS > 1) ? $clog2(TIMEOUT_SLOTS) : 1;
    localparam int TCW = $clog2(TIMEOUT_SLOTS + 1);
    localparam int REMW = ttef_pkg::REM_W;
    localparam int TW  = ttef_pkg::ID_W + REMW;

    ttef_pkg::t_bstate r_state, n_state;
    ttef_pkg::t_cmd    r_cmd, n_cmd;
    logic [FAW-1:0]    r_head, n_head, r_tail, n_tail;
    logic [FCW-1:0]    r_ev_cnt, n_ev_cnt;
    logic [TCW-1:0]    r_to_cnt, n_to_cnt;
    logic [TIMEOUT_SLOTS-1:0] r_live, n_live;
    logic [TAW-1:0]    r_slot, n_slot;
    logic [ttef_pkg::CNT_W-1:0] r_exp, n_exp, r_drop, n_drop;
    ttef_pkg::t_status r_status, n_status;
    logic [ttef_pkg::ID_W-1:0]  r_pid, n_pid;
    logic              r_pvalid, n_pvalid;

    logic              r_o_valid, n_o_valid;
    ttef_pkg::t_status r_o_status, n_o_status;
    logic [ttef_pkg::ID_W-1:0]  r_o_pid, n_o_pid;
    logic              r_o_pvalid, n_o_pvalid;
    logic [ttef_pkg::OCC_W-1:0] r_o_occ, n_o_occ;
    logic [ttef_pkg::CNT_W-1:0] r_o_exp, n_o_exp, r_o_drop, n_o_drop;

    logic                       w_fifo_we;
    logic [ttef_pkg::ID_W-1:0]  w_fifo_wdata, w_fifo_rdata;
    logic                       w_to_we;
    logic [TW-1:0]              w_to_wdata, w_to_rdata;
    logic signed [REMW-1:0]     w_diff;
    logic                       w_expire, w_ev_full, w_to_full, w_last, w_out_free;
    logic [31:0]                w_occ_ext;

    ttef_ram #(.WIDTH(ttef_pkg::ID_W), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (w_fifo_we),
        .i_waddr (r_tail),
        .i_wdata (w_fifo_wdata),
        .i_raddr (r_head),
        .o_rdata (w_fifo_rdata)
    );

    // Each table entry holds the event id above the signed remaining time.
    ttef_ram #(.WIDTH(TW), .DEPTH(TIMEOUT_SLOTS)) u_table_ram (
        .i_clk   (i_clk),
        .i_we    (w_to_we),
        .i_waddr (r_slot),
        .i_wdata (w_to_wdata),
        .i_raddr (r_slot),
        .o_rdata (w_to_rdata)
    );

    assign o_cmd_ready = (r_state == ttef_pkg::B_IDLE);
    assign w_ev_full   = (r_ev_cnt == FCW'(FIFO_DEPTH));
    assign w_to_full   = (r_to_cnt == TCW'(TIMEOUT_SLOTS));
    assign w_last      = (r_slot == TAW'(TIMEOUT_SLOTS - 1));
    assign w_out_free  = !r_o_valid || o_result.ready;
    assign w_diff      = $signed(w_to_rdata[REMW-1:0])
                       - $signed({{(REMW - ttef_pkg::STEP_W){1'b0}}, i_tick_step});
    assign w_expire    = w_diff[REMW-1] || (w_diff == '0);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ttef_pkg::B_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.mode)
                        ttef_pkg::MODE_POST: n_state = ttef_pkg::B_DONE;
                        ttef_pkg::MODE_POP:
                            n_state = (r_ev_cnt == '0) ? ttef_pkg::B_DONE
                                                       : ttef_pkg::B_POP_RD;
                        ttef_pkg::MODE_ADD:
                            n_state = w_to_full ? ttef_pkg::B_DONE
                                                : ttef_pkg::B_ADD_SCAN;
                        ttef_pkg::MODE_TICK: n_state = ttef_pkg::B_TICK_RD;
                        default: n_state = ttef_pkg::B_DONE;
                    endcase
                end
            end
            ttef_pkg::B_POP_RD: n_state = ttef_pkg::B_DONE;
            ttef_pkg::B_ADD_SCAN: begin
                if (!r_live[r_slot]) begin
                    n_state = ttef_pkg::B_DONE;
                end
            end
            ttef_pkg::B_TICK_RD: begin
                if (r_live[r_slot]) begin
                    n_state = ttef_pkg::B_TICK_EX;
                end else if (w_last) begin
                    n_state = ttef_pkg::B_DONE;
                end
            end
            ttef_pkg::B_TICK_EX: begin
                n_state = w_last ? ttef_pkg::B_DONE : ttef_pkg::B_TICK_RD;
            end
            ttef_pkg::B_DONE: begin
                if (w_out_free) begin
                    n_state = ttef_pkg::B_IDLE;
                end
            end
            default: n_state = ttef_pkg::B_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_cmd        = r_cmd;
        n_head       = r_head;
        n_tail       = r_tail;
        n_ev_cnt     = r_ev_cnt;
        n_to_cnt     = r_to_cnt;
        n_live       = r_live;
        n_slot       = r_slot;
        n_exp        = r_exp;
        n_drop       = r_drop;
        n_status     = r_status;
        n_pid        = r_pid;
        n_pvalid     = r_pvalid;
        w_fifo_we    = 1'b0;
        w_fifo_wdata = r_cmd.id;
        w_to_we      = 1'b0;
        w_to_wdata   = {r_cmd.id, 1'b0, r_cmd.duration};
        w_occ_ext    = 32'(r_ev_cnt);

        n_o_valid  = o_result.ready ? 1'b0 : r_o_valid;
        n_o_status = r_o_status;
        n_o_pid    = r_o_pid;
        n_o_pvalid = r_o_pvalid;
        n_o_occ    = r_o_occ;
        n_o_exp    = r_o_exp;
        n_o_drop   = r_o_drop;

        case (r_state)
            ttef_pkg::B_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd    = i_cmd;
                    n_slot   = '0;
                    n_exp    = '0;
                    n_drop   = '0;
                    n_status = ttef_pkg::ST_OK;
                    n_pid    = '0;
                    n_pvalid = 1'b0;
                    case (i_cmd.mode)
                        ttef_pkg::MODE_POST: begin
                            if (w_ev_full) begin
                                n_status = ttef_pkg::ST_FULL;
                            end else begin
                                w_fifo_we    = 1'b1;
                                w_fifo_wdata = i_cmd.id;
                                n_tail   = (r_tail == FAW'(FIFO_DEPTH - 1)) ? '0
                                                                            : r_tail + 1'b1;
                                n_ev_cnt = r_ev_cnt + 1'b1;
                            end
                        end
                        ttef_pkg::MODE_POP: begin
                            if (r_ev_cnt == '0) begin
                                n_status = ttef_pkg::ST_EMPTY;
                            end
                        end
                        ttef_pkg::MODE_ADD: begin
                            if (w_to_full) begin
                                n_status = ttef_pkg::ST_FULL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ttef_pkg::B_POP_RD: begin
                n_pid    = w_fifo_rdata;
                n_pvalid = 1'b1;
                n_head   = (r_head == FAW'(FIFO_DEPTH - 1)) ? '0 : r_head + 1'b1;
                n_ev_cnt = r_ev_cnt - 1'b1;
            end
            ttef_pkg::B_ADD_SCAN: begin
                if (!r_live[r_slot]) begin
                    w_to_we          = 1'b1;
                    n_live[r_slot]   = 1'b1;
                    n_to_cnt         = r_to_cnt + 1'b1;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            ttef_pkg::B_TICK_RD: begin
                if (!r_live[r_slot] && !w_last) begin
                    n_slot = r_slot + 1'b1;
                end
            end
            ttef_pkg::B_TICK_EX: begin
                if (w_expire) begin
                    n_live[r_slot] = 1'b0;
                    if (r_to_cnt != '0) begin
                        n_to_cnt = r_to_cnt - 1'b1;
                    end
                    n_exp = r_exp + 1'b1;
                    if (w_ev_full) begin
                        n_drop = r_drop + 1'b1;
                    end else begin
                        w_fifo_we    = 1'b1;
                        w_fifo_wdata = w_to_rdata[TW-1:REMW];
                        n_tail   = (r_tail == FAW'(FIFO_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                        n_ev_cnt = r_ev_cnt + 1'b1;
                    end
                end else begin
                    w_to_we    = 1'b1;
                    w_to_wdata = {w_to_rdata[TW-1:REMW], w_diff};
                end
                if (!w_last) begin
                    n_slot = r_slot + 1'b1;
                end
            end
            ttef_pkg::B_DONE: begin
                if (r_cmd.mode == ttef_pkg::MODE_ADD) begin
                    w_occ_ext = 32'(r_to_cnt);
                end
                if (w_out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_pid    = r_pid;
                    n_o_pvalid = r_pvalid;
                    n_o_occ    = w_occ_ext[ttef_pkg::OCC_W-1:0];
                    n_o_exp    = r_exp;
                    n_o_drop   = r_drop;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ttef_pkg::B_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_ev_cnt  <= '0;
            r_to_cnt  <= '0;
            r_live    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_ev_cnt  <= n_ev_cnt;
            r_to_cnt  <= n_to_cnt;
            r_live    <= n_live;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_slot     <= n_slot;
        r_exp      <= n_exp;
        r_drop     <= n_drop;
        r_status   <= n_status;
        r_pid      <= n_pid;
        r_pvalid   <= n_pvalid;
        r_o_status <= n_o_status;
        r_o_pid    <= n_o_pid;
        r_o_pvalid <= n_o_pvalid;
        r_o_occ    <= n_o_occ;
        r_o_exp    <= n_o_exp;
        r_o_drop   <= n_o_drop;
    end

    assign o_result.valid         = r_o_valid;
    assign o_result.status        = r_o_status;
    assign o_result.popped_id     = r_o_pid;
    assign o_result.popped_valid  = r_o_pvalid;
    assign o_result.occupancy     = r_o_occ;
    assign o_result.expired_count = r_o_exp;
    assign o_result.dropped_count = r_o_drop;
endmodule

// ----- rtl/core/timeout_table_event_fifo.sv -----
// Top level of the timeout table with event FIFO.
// Command items enter on i_item (mode, event_id, duration_ms) and each gives
// exactly one result item on o_result, in order. Both use valid/ready and an
// item moves at a clock edge where both are high. i_cfg_we writes tick_step.
// The front end decodes items into a two-entry queue; the back end executes
// one command at a time against the event FIFO memory and the timeout table
// memory, then parks the result in an output register.
// Post, full add and empty pop go straight to the result; pop first reads the
// FIFO head, add scans the slots in order until the first free one, and tick
// reads every slot of the table and writes back or expires each live slot.
// The back end runs one command at a time; up to two further items are accepted
// while one executes.
// Reset empties the FIFO and the timeout table (live bits cleared) and sets
// tick_step to 1; there is no clearing pass, so items are taken right away.
// When the receiver stalls, the result holds, the back end waits with the
// next result, the queue fills and i_item.ready drops.
module timeout_table_event_fifo #(
    parameter int FIFO_DEPTH    = 16,
    parameter int TIMEOUT_SLOTS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ttef_in_if.sink                     i_item,
    ttef_out_if.source                  o_result,
    input  logic                        i_cfg_we,
    input  logic [ttef_pkg::STEP_W-1:0] i_cfg_wdata
);
    logic                        w_cmd_valid, w_cmd_ready;
    ttef_pkg::t_cmd              w_cmd;
    logic [ttef_pkg::STEP_W-1:0] r_tick_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_step <= ttef_pkg::STEP_W'(1);
        end else if (i_cfg_we) begin
            r_tick_step <= i_cfg_wdata;
        end
    end

    ttef_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    ttef_back #(
        .FIFO_DEPTH    (FIFO_DEPTH),
        .TIMEOUT_SLOTS (TIMEOUT_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .i_tick_step (r_tick_step),
        .o_result    (o_result)
    );

    // The back end must be busy in the cycle after it takes a command.
    a_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_valid && w_cmd_ready |=> !w_cmd_ready)
        else $error("back end took two commands in consecutive cycles");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && (o_result.status == ttef_pkg::ST_EMPTY)
        |-> !o_result.popped_valid && (o_result.popped_id == '0))
        else $error("empty pop returned an event");

    a_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && (o_result.expired_count != '0 || o_result.dropped_count != '0)
        |-> (o_result.status == ttef_pkg::ST_OK) && !o_result.popped_valid)
        else $error("expiry counts on a result that is not a tick");
endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the timeout table with event FIFO.
module tb_top;

    localparam int FIFO_DEPTH    = 16;
    localparam int TIMEOUT_SLOTS = 8;
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_LIMIT   = 3000;
    localparam int NUM_PHASES    = 7;
    localparam int ID_W          = ttef_pkg::ID_W;
    localparam int DUR_W         = ttef_pkg::DUR_W;
    localparam int STEP_W        = ttef_pkg::STEP_W;
    localparam int REM_W         = ttef_pkg::REM_W;
    localparam int OCC_W         = ttef_pkg::OCC_W;
    localparam int CNT_W         = ttef_pkg::CNT_W;

    typedef struct packed {
        ttef_pkg::t_status status;
        logic [ID_W-1:0]   popped_id;
        logic              popped_valid;
        logic [OCC_W-1:0]  occupancy;
        logic [CNT_W-1:0]  expired_count;
        logic [CNT_W-1:0]  dropped_count;
    } t_reply;

    typedef struct {
        ttef_pkg::t_mode   mode;
        logic [ID_W-1:0]   id;
        logic [DUR_W-1:0]  dur;
        bit                has_reply;
        t_reply            reply;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [STEP_W-1:0] cfg_wdata;

    ttef_in_if  cmd_if ();
    ttef_out_if rsp_if ();

    timeout_table_event_fifo #(
        .FIFO_DEPTH    (FIFO_DEPTH),
        .TIMEOUT_SLOTS (TIMEOUT_SLOTS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (cmd_if),
        .o_result    (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the block state, advanced as each item is accepted.
    logic [ID_W-1:0]         event_fifo [$];
    logic signed [REM_W-1:0] slot_left [TIMEOUT_SLOTS];
    logic [ID_W-1:0]         slot_id [TIMEOUT_SLOTS];
    logic                    slot_live [TIMEOUT_SLOTS];
    int unsigned             timer_count;
    logic [STEP_W-1:0]       tick_step;

    t_reply replies_due [$];
    int     mismatches   = 0;
    int     quiet_cycles = 0;
    bit     gaps_on;
    bit     stalls_on;
    int     stall_left   = 0;

    t_row dir_rows [0:18] = '{
        '{ttef_pkg::MODE_POP,  8'h00, 32'd0,         1'b1,
          '{ttef_pkg::ST_EMPTY, 8'h00, 1'b0, 5'd0, 4'd0, 4'd0}},
        '{ttef_pkg::MODE_TICK, 8'h00, 32'd0,         1'b1,
          '{ttef_pkg::ST_OK,    8'h00, 1'b0, 5'd0, 4'd0, 4'd0}},
        '{ttef_pkg::MODE_POST, 8'hFF, 32'd0,         1'b1,
          '{ttef_pkg::ST_OK,    8'h00, 1'b0, 5'd1, 4'd0, 4'd0}},
        '{ttef_pkg::MODE_POST, 8'h00, 32'd0,         1'b1,
          '{ttef_pkg::ST_OK,    8'h00, 1'b0, 5'd2, 4'd0, 4'd0}},
        '{ttef_pkg::MODE_POP,  8'h00, 32'd0,         1'b1,
          '{ttef_pkg::ST_OK,    8'hFF, 1'b1, 5'd1, 4'd0, 4'd0}},
        '{ttef_pkg::MODE_ADD,  8'hA5, 32'd0,         1'b1,
          '{ttef_pkg::ST_OK,    8'h00, 1'b0, 5'd1, 4'd0, 4'd0}},
        '{ttef_pkg::MODE_ADD,  8'h5A, 32'hFFFF_FFFF, 1'b1,
          '{ttef_pkg::ST_OK,    8'h00, 1'b0, 5'd2, 4'd0, 4'd0}},
        '{ttef_pkg::MODE_ADD,  8'h01, 32'd1,         1'b0, '0},
        '{ttef_pkg::MODE_ADD,  8'h02, 32'd2,         1'b0, '0},
        '{ttef_pkg::MODE_ADD,  8'h03, 32'd3,         1'b0, '0},
        '{ttef_pkg::MODE_ADD,  8'h04, 32'd1000,      1'b0, '0},
        '{ttef_pkg::MODE_ADD,  8'h05, 32'd1001,      1'b0, '0},
        '{ttef_pkg::MODE_ADD,  8'h06, 32'h7FFF_FFFF, 1'b0, '0},
        '{ttef_pkg::MODE_ADD,  8'h07, 32'd5,         1'b1,
          '{ttef_pkg::ST_FULL,  8'h00, 1'b0, 5'd8, 4'd0, 4'd0}},
        '{ttef_pkg::MODE_TICK, 8'h00, 32'd0,         1'b0, '0},
        '{ttef_pkg::MODE_POP,  8'h00, 32'd0,         1'b0, '0},
        '{ttef_pkg::MODE_POP,  8'h00, 32'd0,         1'b0, '0},
        '{ttef_pkg::MODE_POP,  8'h00, 32'd0,         1'b0, '0},
        '{ttef_pkg::MODE_POP,  8'h00, 32'd0,         1'b0, '0}
    };

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Runs one command against the shadow state and returns its reply.
    function automatic t_reply apply_command(input ttef_pkg::t_mode cmd,
                                             input logic [ID_W-1:0] id,
                                             input logic [DUR_W-1:0] dur);
        t_reply r;
        int     s;
        r = '{ttef_pkg::ST_OK, '0, 1'b0, '0, '0, '0};
        case (cmd)
            ttef_pkg::MODE_POST: begin
                if (event_fifo.size() < FIFO_DEPTH) begin
                    event_fifo.push_back(id);
                end else begin
                    r.status = ttef_pkg::ST_FULL;
                end
                r.occupancy = OCC_W'(event_fifo.size());
            end
            ttef_pkg::MODE_POP: begin
                if (event_fifo.size() == 0) begin
                    r.status = ttef_pkg::ST_EMPTY;
                end else begin
                    r.popped_id    = event_fifo.pop_front();
                    r.popped_valid = 1'b1;
                end
                r.occupancy = OCC_W'(event_fifo.size());
            end
            ttef_pkg::MODE_ADD: begin
                s = 0;
                while (s < TIMEOUT_SLOTS && slot_live[s]) s++;
                if (s == TIMEOUT_SLOTS) begin
                    r.status = ttef_pkg::ST_FULL;
                end else begin
                    slot_live[s] = 1'b1;
                    slot_id[s]   = id;
                    slot_left[s] = $signed({1'b0, dur});
                    timer_count++;
                end
                r.occupancy = OCC_W'(timer_count);
            end
            default: begin
                // Expiries are pushed in slot order; a full FIFO drops them.
                for (s = 0; s < TIMEOUT_SLOTS; s++) begin
                    if (slot_live[s]) begin
                        slot_left[s] = slot_left[s]
                                       - $signed({{(REM_W-STEP_W){1'b0}}, tick_step});
                        if (slot_left[s] <= 0) begin
                            slot_live[s] = 1'b0;
                            if (timer_count > 0) timer_count--;
                            r.expired_count = r.expired_count + 1'b1;
                            if (event_fifo.size() < FIFO_DEPTH) begin
                                event_fifo.push_back(slot_id[s]);
                            end else begin
                                r.dropped_count = r.dropped_count + 1'b1;
                            end
                        end
                    end
                end
                r.occupancy = OCC_W'(event_fifo.size());
            end
        endcase
        return r;
    endfunction

    // Presents one item, waits for its handshake, then records the reply it owes.
    task automatic send_item(input ttef_pkg::t_mode cmd, input logic [ID_W-1:0] id,
                             input logic [DUR_W-1:0] dur, input bit has_reply,
                             input t_reply fixed_reply);
        t_reply pred;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.mode        <= cmd;
        cmd_if.event_id    <= id;
        cmd_if.duration_ms <= dur;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        pred = apply_command(cmd, id, dur);
        replies_due.push_back(has_reply ? fixed_reply : pred);
    endtask

    task automatic write_tick_step(input logic [STEP_W-1:0] value);
        cmd_if.valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        tick_step  = value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Receiver side: ready drops for bursts while stalls are enabled.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            rsp_if.ready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left   <= $urandom_range(1, 18) - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (replies_due.size() == 0) begin
                $error("reply item arrived with no command pending");
                mismatches++;
            end else begin
                want = replies_due.pop_front();
                if (rsp_if.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                    mismatches++;
                end
                if (rsp_if.popped_id !== want.popped_id) begin
                    $error("popped_id: expected %0d, got %0d", want.popped_id,
                           rsp_if.popped_id);
                    mismatches++;
                end
                if (rsp_if.popped_valid !== want.popped_valid) begin
                    $error("popped_valid: expected %0d, got %0d", want.popped_valid,
                           rsp_if.popped_valid);
                    mismatches++;
                end
                if (rsp_if.occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy,
                           rsp_if.occupancy);
                    mismatches++;
                end
                if (rsp_if.expired_count !== want.expired_count) begin
                    $error("expired_count: expected %0d, got %0d", want.expired_count,
                           rsp_if.expired_count);
                    mismatches++;
                end
                if (rsp_if.dropped_count !== want.dropped_count) begin
                    $error("dropped_count: expected %0d, got %0d", want.dropped_count,
                           rsp_if.dropped_count);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: too long without any item moving on either side ends the run.
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned       step_plan [NUM_PHASES];
        int                phase_len;
        int                lean;
        int                pick;
        int                long_slots;
        int                n;
        int                s;
        ttef_pkg::t_mode   cmd;
        logic [DUR_W-1:0]  dur;

        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        cmd_if.valid       <= 1'b0;
        cmd_if.mode        <= ttef_pkg::MODE_POST;
        cmd_if.event_id    <= '0;
        cmd_if.duration_ms <= '0;
        gaps_on      = 1'b1;
        stalls_on    = 1'b1;

        event_fifo.delete();
        for (s = 0; s < TIMEOUT_SLOTS; s++) begin
            slot_left[s] = '0;
            slot_id[s]   = '0;
            slot_live[s] = 1'b0;
        end
        timer_count = 0;
        tick_step   = STEP_W'(1);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].mode, dir_rows[i].id, dir_rows[i].dur,
                      dir_rows[i].has_reply, dir_rows[i].reply);
        end

        // Step settings cover both ends of the range and zero.
        step_plan = '{1000, 0, 1023, 1, $urandom_range(1, 1000), 300, 1};
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_tick_step(STEP_W'(step_plan[ph]));
            phase_len = (step_plan[ph] == 0) ? 40 : 125;
            lean = 0;
            for (n = 0; n < phase_len; n++) begin
                if (n % 40 == 0) begin
                    lean      = $urandom_range(0, 2);
                    gaps_on   = (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
                    stalls_on = (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
                end
                // Fill-leaning chunks drive the FIFO to full; drain-leaning ones empty it.
                pick = $urandom_range(0, 99);
                case (lean)
                    0:       cmd = (pick < 40) ? ttef_pkg::MODE_POST :
                                   (pick < 55) ? ttef_pkg::MODE_POP :
                                   (pick < 80) ? ttef_pkg::MODE_ADD : ttef_pkg::MODE_TICK;
                    1:       cmd = (pick < 10) ? ttef_pkg::MODE_POST :
                                   (pick < 55) ? ttef_pkg::MODE_POP :
                                   (pick < 70) ? ttef_pkg::MODE_ADD : ttef_pkg::MODE_TICK;
                    default: cmd = ttef_pkg::t_mode'(pick % 4);
                endcase
                // Very long timeouts never expire, so only a few may hold a slot.
                long_slots = 0;
                for (s = 0; s < TIMEOUT_SLOTS; s++) begin
                    if (slot_live[s] && slot_left[s] > (1 << 20)) long_slots++;
                end
                if ($urandom_range(0, 31) == 0 && long_slots < 3) begin
                    dur = $urandom;
                end else begin
                    dur = $urandom_range(0, int'(tick_step) * 8 + 2);
                end
                send_item(cmd, ID_W'($urandom_range(0, 255)), dur, 1'b0, '0);
            end
        end

        cmd_if.valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
